/* rtl/gtpusc_pkg.sv */
// Shared types and constants for the GTP-U / IPv4 steering classifier.
// Used by every module under rtl but gtpusc_checker; depends on nothing else.
package gtpusc_pkg;

  localparam logic [31:0] SEED_RESET  = 32'hEAAD8405;
  localparam logic [15:0] PORT_RESET  = 16'd2152;
  localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;
  localparam logic [6:0]  POS_MAX     = 7'd127;

  // Byte offsets inside the Ethernet frame.
  localparam logic [6:0] POS_ETYPE_HI = 7'd12;
  localparam logic [6:0] POS_ETYPE_LO = 7'd13;
  localparam logic [6:0] POS_IHL      = 7'd14;
  localparam logic [6:0] POS_PROTO    = 7'd23;
  localparam logic [6:0] POS_MAC_END  = 7'd6;
  localparam logic [6:0] UDP_BASE     = 7'd16;
  localparam logic [6:0] POS_DEST_IP  = 7'd30;
  localparam logic [6:0] INNER_BASE   = 7'd42;

  localparam logic [7:0] ETYPE_HI_IPV4 = 8'h08;
  localparam logic [7:0] ETYPE_LO_IPV4 = 8'h00;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] BYTE_ONES     = 8'hFF;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INTERFACE_MODE  = 3'd0,
    CFG_HASH_MODE       = 3'd1,
    CFG_HASH_SEED       = 3'd2,
    CFG_LOCAL_IPV4      = 3'd3,
    CFG_TUNNEL_UDP_PORT = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic        interface_mode;
    logic        hash_mode;
    logic [31:0] hash_seed;
    logic [31:0] local_ipv4;
    logic [15:0] tunnel_udp_port;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       checksum_bad;
  } beat_t;

  typedef struct packed {
    logic        slow_path;
    logic [31:0] flow_hash;
    logic        hash_valid;
  } result_t;

endpackage

/* rtl/gtpusc_cfg.sv */
// Configuration register file for the steering classifier.
// Depends on gtpusc_pkg for the register index codes and the cfg_t layout.
module gtpusc_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [gtpusc_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [31:0]                        wr_data,
  output gtpusc_pkg::cfg_t                   cfg
);

  gtpusc_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.interface_mode  <= 1'b0;
      regs.hash_mode       <= 1'b0;
      regs.hash_seed       <= gtpusc_pkg::SEED_RESET;
      regs.local_ipv4      <= 32'd0;
      regs.tunnel_udp_port <= gtpusc_pkg::PORT_RESET;
    end else if (wr_en) begin
      case (gtpusc_pkg::cfg_index_t'(wr_index))
        gtpusc_pkg::CFG_INTERFACE_MODE:  regs.interface_mode  <= wr_data[0];
        gtpusc_pkg::CFG_HASH_MODE:       regs.hash_mode       <= wr_data[0];
        gtpusc_pkg::CFG_HASH_SEED:       regs.hash_seed       <= wr_data;
        gtpusc_pkg::CFG_LOCAL_IPV4:      regs.local_ipv4      <= wr_data;
        gtpusc_pkg::CFG_TUNNEL_UDP_PORT: regs.tunnel_udp_port <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

/* rtl/gtpusc_crc.sv */
// One byte step of reflected CRC32C, no final inversion.
// Depends on gtpusc_pkg for the polynomial.
module gtpusc_crc (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ gtpusc_pkg::CRC32C_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

/* rtl/gtpusc_parser.sv */
// Per-frame header tracker and steering decision.
// Depends on gtpusc_pkg and on gtpusc_crc for the hash byte step.
module gtpusc_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  gtpusc_pkg::beat_t   beat,
  input  gtpusc_pkg::cfg_t    cfg,
  output gtpusc_pkg::result_t res
);

  logic [6:0]  byte_position, byte_position_next;
  logic [5:0]  ip_header_bytes, ip_header_bytes_next;
  logic        ethertype_ipv4, ethertype_ipv4_next;
  logic        protocol_udp, protocol_udp_next;
  logic        port_high_byte_match, port_high_byte_match_next;
  logic        tunnel_port_match, tunnel_port_match_next;
  logic        all_ones_mac, all_ones_mac_next;
  logic        destination_differs, destination_differs_next;
  logic [31:0] hash_register, hash_register_next;
  logic [7:0]  last_octet, last_octet_next;
  logic        address_complete, address_complete_next;

  logic [31:0] hash_cur;
  logic [31:0] hash_stepped;
  logic [6:0]  port_pos;
  logic [6:0]  addr_start;
  logic        in_addr;
  logic [1:0]  addr_k;
  logic [7:0]  want;
  logic        fast;

  // The hash restarts from the seed on the first byte of every frame.
  assign hash_cur = (byte_position == 7'd0) ? cfg.hash_seed : hash_register;

  gtpusc_crc u_crc (
    .crc_in  (hash_cur),
    .data    (beat.data_byte),
    .crc_out (hash_stepped)
  );

  assign port_pos   = gtpusc_pkg::UDP_BASE + {1'b0, ip_header_bytes};
  assign addr_start = cfg.interface_mode ? gtpusc_pkg::POS_DEST_IP
                                         : gtpusc_pkg::INNER_BASE + {1'b0, ip_header_bytes};
  assign in_addr    = (byte_position >= addr_start) && (byte_position < addr_start + 7'd4);
  assign addr_k     = 2'(byte_position - addr_start);
  // Address byte k sits in bits 8*(3-k) and up; 3-k is ~k on two bits.
  assign want       = cfg.local_ipv4[{~addr_k, 3'b000} +: 8];

  always_comb begin
    byte_position_next        = byte_position;
    ip_header_bytes_next      = ip_header_bytes;
    ethertype_ipv4_next       = ethertype_ipv4;
    protocol_udp_next         = protocol_udp;
    port_high_byte_match_next = port_high_byte_match;
    tunnel_port_match_next    = tunnel_port_match;
    all_ones_mac_next         = all_ones_mac;
    destination_differs_next  = destination_differs;
    hash_register_next        = hash_cur;
    last_octet_next           = last_octet;
    address_complete_next     = address_complete;

    if (byte_position < gtpusc_pkg::POS_MAC_END && beat.data_byte != gtpusc_pkg::BYTE_ONES) begin
      all_ones_mac_next = 1'b0;
    end
    if (byte_position == gtpusc_pkg::POS_ETYPE_HI) begin
      ethertype_ipv4_next = (beat.data_byte == gtpusc_pkg::ETYPE_HI_IPV4);
    end
    if (byte_position == gtpusc_pkg::POS_ETYPE_LO) begin
      ethertype_ipv4_next = ethertype_ipv4 && (beat.data_byte == gtpusc_pkg::ETYPE_LO_IPV4);
    end
    if (byte_position == gtpusc_pkg::POS_IHL) begin
      ip_header_bytes_next = {beat.data_byte[3:0], 2'b00};
    end
    if (byte_position == gtpusc_pkg::POS_PROTO) begin
      protocol_udp_next = (beat.data_byte == gtpusc_pkg::PROTO_UDP);
    end
    if (byte_position == port_pos) begin
      port_high_byte_match_next = (beat.data_byte == cfg.tunnel_udp_port[15:8]);
    end
    if (byte_position == port_pos + 7'd1) begin
      tunnel_port_match_next = port_high_byte_match
                               && (beat.data_byte == cfg.tunnel_udp_port[7:0]);
    end
    if (in_addr) begin
      if (beat.data_byte != want) begin
        destination_differs_next = 1'b1;
      end
      hash_register_next = hash_stepped;
      if (addr_k == 2'd3) begin
        last_octet_next       = beat.data_byte;
        address_complete_next = 1'b1;
      end
    end
    if (byte_position < gtpusc_pkg::POS_MAX) begin
      byte_position_next = byte_position + 7'd1;
    end

    if (cfg.interface_mode) begin
      fast = !beat.checksum_bad && ethertype_ipv4_next && destination_differs_next
             && !all_ones_mac_next && address_complete_next;
    end else begin
      fast = !beat.checksum_bad && ethertype_ipv4_next && protocol_udp_next
             && tunnel_port_match_next && address_complete_next;
    end

    res.slow_path  = !fast;
    res.hash_valid = fast;
    if (!fast) begin
      res.flow_hash = 32'd0;
    end else if (cfg.hash_mode) begin
      res.flow_hash = {24'd0, last_octet_next};
    end else begin
      res.flow_hash = hash_register_next;
    end

    if (beat.last_byte) begin
      byte_position_next        = 7'd0;
      ip_header_bytes_next      = 6'd0;
      ethertype_ipv4_next       = 1'b0;
      protocol_udp_next         = 1'b0;
      port_high_byte_match_next = 1'b0;
      tunnel_port_match_next    = 1'b0;
      all_ones_mac_next         = 1'b1;
      destination_differs_next  = 1'b0;
      hash_register_next        = cfg.hash_seed;
      last_octet_next           = 8'd0;
      address_complete_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= 7'd0;
      ip_header_bytes      <= 6'd0;
      ethertype_ipv4       <= 1'b0;
      protocol_udp         <= 1'b0;
      port_high_byte_match <= 1'b0;
      tunnel_port_match    <= 1'b0;
      all_ones_mac         <= 1'b1;
      destination_differs  <= 1'b0;
      hash_register        <= gtpusc_pkg::SEED_RESET;
      last_octet           <= 8'd0;
      address_complete     <= 1'b0;
    end else if (step) begin
      byte_position        <= byte_position_next;
      ip_header_bytes      <= ip_header_bytes_next;
      ethertype_ipv4       <= ethertype_ipv4_next;
      protocol_udp         <= protocol_udp_next;
      port_high_byte_match <= port_high_byte_match_next;
      tunnel_port_match    <= tunnel_port_match_next;
      all_ones_mac         <= all_ones_mac_next;
      destination_differs  <= destination_differs_next;
      hash_register        <= hash_register_next;
      last_octet           <= last_octet_next;
      address_complete     <= address_complete_next;
    end
  end

endmodule

/* rtl/gtpusc_pkg_unused_guard.sv */
// Output stage of the steering classifier: holds one finished result.
// Depends on gtpusc_pkg for the result_t layout.
module gtpusc_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  gtpusc_pkg::result_t load_res,
  input  logic                take,
  output logic                valid,
  output gtpusc_pkg::result_t res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

endmodule

/* rtl/gtpu_ipv4_packet_steering_classifier_core.sv */
// Top level of the GTP-U / IPv4 packet steering classifier.
// Depends on gtpusc_pkg, gtpusc_cfg, gtpusc_parser and gtpusc_out_stage.
//
//  channel  direction  handshake           payload
//  s_*      in         s_tvalid/s_tready   frame bytes, one per beat
//  m_*      out        m_tvalid/m_tready   one steering result per frame
//  cfg_*    in         cfg_valid/cfg_ready register index and write data
//
// One byte beat is taken per cycle while no waiting result stalls it. Each beat sits
// in the input register, where the header tracker and one CRC32C byte step judge it;
// the result of a frame's last beat is loaded into the output register as that beat
// leaves. A waiting result stalls only the last beat of the next frame.
// Reset is synchronous on rst and clears all control state, not the data registers.
module gtpu_ipv4_packet_steering_classifier_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] data_byte
  input  logic                               s_tlast,   // last_byte
  input  logic                               s_tuser,   // [0] checksum_bad
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [31:0]                        m_tdata,   // [31:0] flow_hash
  output logic [1:0]                         m_tuser,   // [0] slow_path, [1] hash_valid
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gtpusc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                        cfg_data
);

  gtpusc_pkg::cfg_t    cfg;
  gtpusc_pkg::beat_t   in_beat;
  gtpusc_pkg::result_t frame_res;
  gtpusc_pkg::result_t out_res;
  logic                in_valid;
  logic                advance;

  assign cfg_ready = 1'b1;

  gtpusc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // A beat moves on unless it would produce a result while the output is held.
  assign advance  = in_valid && (!in_beat.last_byte || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_beat.data_byte    <= s_tdata;
      in_beat.last_byte    <= s_tlast;
      in_beat.checksum_bad <= s_tuser;
    end
  end

  gtpusc_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .beat (in_beat),
    .cfg  (cfg),
    .res  (frame_res)
  );

  gtpusc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && in_beat.last_byte),
    .load_res (frame_res),
    .take     (m_tready),
    .valid    (m_tvalid),
    .res      (out_res)
  );

  assign m_tdata = out_res.flow_hash;
  assign m_tuser = {out_res.hash_valid, out_res.slow_path};

endmodule

/* rtl/gtpusc_checker.sv */
// Port-level checks for the steering classifier, bound to its top level.
// Depends only on the top level's ports.
module gtpusc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A held result keeps its payload until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // The hash is marked valid exactly on the fast path.
  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[0] != m_tuser[1])
    else $error("hash_valid does not mirror slow_path");

  // Slow-path results carry a zero hash.
  a_zero_hash: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
    else $error("slow-path result carries a hash");

  // No result is shown in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind gtpu_ipv4_packet_steering_classifier_core gtpusc_checker u_gtpusc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* bench/gtpu_ipv4_packet_steering_classifier_core_test.sv */
// Self-checking bench for the GTP-U / IPv4 steering classifier core.
// Builds frames byte by byte, predicts each steering result and compares it.
// Depends on gtpusc_pkg and gtpu_ipv4_packet_steering_classifier_core.
module gtpu_ipv4_packet_steering_classifier_core_test;
  import gtpusc_pkg::*;

  typedef enum logic [1:0] {FK_TUNNEL, FK_INET, FK_NOISE} frame_kind_t;
  typedef enum logic [3:0] {
    FL_NONE, FL_ETYPE_HI, FL_ETYPE_LO, FL_PROTO, FL_PORT_HI, FL_PORT_LO,
    FL_BCAST, FL_LOCAL, FL_SHORT
  } flaw_t;

  typedef struct packed {
    logic        wr;
    cfg_t        regs;
    frame_kind_t kind;
    logic [3:0]  ihl;
    logic [7:0]  len;
    logic [31:0] addr;
    logic        chk_bad;
    flaw_t       flaw;
    logic        typed;
    result_t     res;
  } steer_row_t;

  typedef struct packed {
    logic    typed;
    result_t res;
  } frame_note_t;

  localparam cfg_t    RST_REGS = '{1'b0, 1'b0, SEED_RESET, 32'h0, PORT_RESET};
  localparam result_t SLOW_RES = '{1'b1, 32'h0, 1'b0};
  localparam int      N_ROWS   = 22;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h0;
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = 32'h0;

  gtpu_ipv4_packet_steering_classifier_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted register contents and per-frame header tracking.
  cfg_t        cfg_now;
  int          pos;
  int          ihl_bytes;
  logic        is_ipv4, is_udp, port_hi_ok, port_ok, mac_ones, dst_differs, addr_done;
  logic [31:0] crc_acc;
  logic [7:0]  tail_octet;

  result_t     steer_expect [$];
  frame_note_t frame_notes [$];
  logic [7:0]  frame_bytes [$];
  int          mismatch_count = 0;
  logic        sender_burst = 1'b0;
  cfg_t        drv_cfg = RST_REGS;
  int          bytes_sent = 0;
  int          frames_sent = 0;

  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++)
      c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic clear_frame_state();
    pos = 0;
    ihl_bytes = 0;
    is_ipv4 = 1'b0;
    is_udp = 1'b0;
    port_hi_ok = 1'b0;
    port_ok = 1'b0;
    mac_ones = 1'b1;
    dst_differs = 1'b0;
    crc_acc = cfg_now.hash_seed;
    tail_octet = 8'h0;
    addr_done = 1'b0;
  endtask

  task automatic judge_byte(input logic [7:0] b, input logic lst, input logic chk_bad,
                            output logic emit, output result_t r);
    int   port_at, addr_at, k;
    logic fast;
    port_at = int'(UDP_BASE) + ihl_bytes;
    addr_at = cfg_now.interface_mode ? int'(POS_DEST_IP) : int'(INNER_BASE) + ihl_bytes;
    emit = 1'b0;
    r = '0;
    if (pos == 0) crc_acc = cfg_now.hash_seed;
    if (pos < int'(POS_MAC_END) && b != BYTE_ONES) mac_ones = 1'b0;
    if (pos == int'(POS_ETYPE_HI)) is_ipv4 = (b == ETYPE_HI_IPV4);
    if (pos == int'(POS_ETYPE_LO)) is_ipv4 = is_ipv4 && (b == ETYPE_LO_IPV4);
    if (pos == int'(POS_IHL)) ihl_bytes = int'(b[3:0]) << 2;
    if (pos == int'(POS_PROTO)) is_udp = (b == PROTO_UDP);
    if (pos == port_at) port_hi_ok = (b == cfg_now.tunnel_udp_port[15:8]);
    if (pos == port_at + 1) port_ok = port_hi_ok && (b == cfg_now.tunnel_udp_port[7:0]);
    if (pos >= addr_at && pos < addr_at + 4) begin
      k = pos - addr_at;
      if (b != 8'(cfg_now.local_ipv4 >> (8 * (3 - k)))) dst_differs = 1'b1;
      crc_acc = crc32c_byte(crc_acc, b);
      if (k == 3) begin
        tail_octet = b;
        addr_done = 1'b1;
      end
    end
    if (pos < int'(POS_MAX)) pos++;
    if (lst) begin
      if (cfg_now.interface_mode)
        fast = !chk_bad && is_ipv4 && dst_differs && !mac_ones && addr_done;
      else
        fast = !chk_bad && is_ipv4 && is_udp && port_ok && addr_done;
      emit = 1'b1;
      r.slow_path = !fast;
      r.flow_hash = fast ? (cfg_now.hash_mode ? {24'h0, tail_octet} : crc_acc) : 32'h0;
      r.hash_valid = fast;
      clear_frame_state();
    end
  endtask

  // Predictor and checker share one block so queue order is fixed per edge.
  logic        pred_emit;
  result_t     pred_res;
  result_t     want;
  frame_note_t cur_note;

  always @(posedge clk) begin
    if (rst) begin
      cfg_now = RST_REGS;
      clear_frame_state();
    end else begin
      if (m_tvalid && m_tready) begin
        if (steer_expect.size() == 0) begin
          $display("%0t unexpected result beat: flow_hash %h tuser %b", $time, m_tdata, m_tuser);
          mismatch_count++;
        end else begin
          want = steer_expect.pop_front();
          if (m_tuser[0] !== want.slow_path) begin
            $display("%0t slow_path: expected %0b, got %0b", $time, want.slow_path, m_tuser[0]);
            mismatch_count++;
          end
          if (m_tuser[1] !== want.hash_valid) begin
            $display("%0t hash_valid: expected %0b, got %0b", $time, want.hash_valid,
                     m_tuser[1]);
            mismatch_count++;
          end
          if (m_tdata !== want.flow_hash) begin
            $display("%0t flow_hash: expected %h, got %h", $time, want.flow_hash, m_tdata);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_INTERFACE_MODE:  cfg_now.interface_mode = cfg_data[0];
          CFG_HASH_MODE:       cfg_now.hash_mode = cfg_data[0];
          CFG_HASH_SEED:       cfg_now.hash_seed = cfg_data;
          CFG_LOCAL_IPV4:      cfg_now.local_ipv4 = cfg_data;
          CFG_TUNNEL_UDP_PORT: cfg_now.tunnel_udp_port = cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        judge_byte(s_tdata, s_tlast, s_tuser, pred_emit, pred_res);
        if (pred_emit) begin
          cur_note = frame_notes.pop_front();
          steer_expect.push_back(cur_note.typed ? cur_note.res : pred_res);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  int ready_hold = 0;

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 1)) begin
      m_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 30);
    end else begin
      m_tready <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Registers change only with no frame in flight.
  task automatic program_regs(input cfg_t c);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (steer_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_INTERFACE_MODE, {31'h0, c.interface_mode});
    write_reg(CFG_HASH_MODE, {31'h0, c.hash_mode});
    write_reg(CFG_HASH_SEED, c.hash_seed);
    write_reg(CFG_LOCAL_IPV4, c.local_ipv4);
    write_reg(CFG_TUNNEL_UDP_PORT, {16'h0, c.tunnel_udp_port});
    cfg_valid <= 1'b0;
    drv_cfg = c;
  endtask

  task automatic put_byte(input int idx, input logic [7:0] v);
    if (idx < frame_bytes.size()) frame_bytes[idx] = v;
  endtask

  task automatic build_frame(input frame_kind_t k, input int ihl, input int len_req,
                             input logic [31:0] addr_in, input flaw_t fl);
    int          need, n, port_at, addr_at;
    logic [31:0] addr;
    need = (k == FK_TUNNEL) ? int'(INNER_BASE) + 4 * ihl + 4 : int'(POS_DEST_IP) + 4;
    if (len_req > 0) n = len_req;
    else n = (fl == FL_SHORT) ? need - 1 : need;
    addr = (fl == FL_LOCAL) ? drv_cfg.local_ipv4 : addr_in;
    frame_bytes.delete();
    for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (k != FK_NOISE) begin
      // A unicast destination MAC unless the frame is meant to be broadcast.
      put_byte(0, 8'h02);
      put_byte(int'(POS_ETYPE_HI), ETYPE_HI_IPV4);
      put_byte(int'(POS_ETYPE_LO), ETYPE_LO_IPV4);
      put_byte(int'(POS_IHL), {4'h4, 4'(ihl)});
      put_byte(int'(POS_PROTO), PROTO_UDP);
      port_at = int'(UDP_BASE) + 4 * ihl;
      put_byte(port_at, drv_cfg.tunnel_udp_port[15:8]);
      put_byte(port_at + 1, drv_cfg.tunnel_udp_port[7:0]);
      addr_at = (k == FK_TUNNEL) ? int'(INNER_BASE) + 4 * ihl : int'(POS_DEST_IP);
      for (int j = 0; j < 4; j++) put_byte(addr_at + j, 8'(addr >> (8 * (3 - j))));
      case (fl)
        FL_ETYPE_HI: put_byte(int'(POS_ETYPE_HI), 8'h86);
        FL_ETYPE_LO: put_byte(int'(POS_ETYPE_LO), 8'hDD);
        FL_PROTO:    put_byte(int'(POS_PROTO), 8'd6);
        FL_PORT_HI:  put_byte(port_at, drv_cfg.tunnel_udp_port[15:8] ^ 8'h01);
        FL_PORT_LO:  put_byte(port_at + 1, ~drv_cfg.tunnel_udp_port[7:0]);
        FL_BCAST:    for (int j = 0; j < int'(POS_MAC_END); j++) put_byte(j, BYTE_ONES);
        default: ;
      endcase
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic lst, input logic chk_bad);
    int gap;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= lst;
    s_tuser <= chk_bad;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_frame(input logic chk_bad, input logic typed, input result_t res);
    frame_note_t fn;
    int          n;
    fn.typed = typed;
    fn.res = res;
    n = frame_bytes.size();
    frame_notes.push_back(fn);
    // The checksum flag only counts on the last beat; elsewhere it is noise.
    for (int i = 0; i < n; i++)
      send_beat(frame_bytes[i], i == n - 1, (i == n - 1) ? chk_bad : 1'($urandom_range(0, 1)));
    bytes_sent += n;
    frames_sent++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  steer_row_t dir_rows [N_ROWS];

  initial begin
    cfg_t        rc;
    frame_kind_t k;
    flaw_t       fl;
    int          ihl, need, len, r;

    dir_rows[0]  = '{1'b0, RST_REGS, FK_NOISE, 4'd5, 8'd1, 32'h0, 1'b0, FL_NONE, 1'b1,
                     SLOW_RES};
    dir_rows[1]  = '{1'b0, RST_REGS, FK_TUNNEL, 4'd5, 8'd0, 32'hC0A80101, 1'b0, FL_NONE, 1'b0,
                     SLOW_RES};
    dir_rows[2]  = '{1'b0, RST_REGS, FK_TUNNEL, 4'd5, 8'd0, 32'hC0A80101, 1'b1, FL_NONE, 1'b1,
                     SLOW_RES};
    dir_rows[3]  = '{1'b0, RST_REGS, FK_TUNNEL, 4'd5, 8'd0, 32'hC0A80102, 1'b0, FL_SHORT, 1'b1,
                     SLOW_RES};
    dir_rows[4]  = '{1'b0, RST_REGS, FK_TUNNEL, 4'd0, 8'd0, 32'h0A141E28, 1'b0, FL_NONE, 1'b0,
                     SLOW_RES};
    dir_rows[5]  = '{1'b0, RST_REGS, FK_TUNNEL, 4'd15, 8'd0, 32'h80000001, 1'b0, FL_NONE, 1'b0,
                     SLOW_RES};
    dir_rows[6]  = '{1'b0, RST_REGS, FK_TUNNEL, 4'd5, 8'd0, 32'h01020304, 1'b0, FL_PORT_LO,
                     1'b1, SLOW_RES};
    dir_rows[7]  = '{1'b0, RST_REGS, FK_TUNNEL, 4'd5, 8'd0, 32'h01020304, 1'b0, FL_PROTO, 1'b1,
                     SLOW_RES};
    dir_rows[8]  = '{1'b0, RST_REGS, FK_TUNNEL, 4'd5, 8'd0, 32'h01020304, 1'b0, FL_ETYPE_LO,
                     1'b1, SLOW_RES};
    dir_rows[9]  = '{1'b1, '{1'b0, 1'b1, 32'h0, 32'hFFFFFFFF, 16'h0000}, FK_TUNNEL, 4'd5, 8'd0,
                     32'h0A0000FF, 1'b0, FL_NONE, 1'b1, '{1'b0, 32'hFF, 1'b1}};
    dir_rows[10] = '{1'b1, '{1'b0, 1'b0, 32'h0, 32'hFFFFFFFF, 16'hFFFF}, FK_TUNNEL, 4'd5, 8'd0,
                     32'h0, 1'b0, FL_NONE, 1'b0, SLOW_RES};
    dir_rows[11] = '{1'b1, '{1'b1, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, PORT_RESET}, FK_INET, 4'd5,
                     8'd0, 32'hFFFFFFFE, 1'b0, FL_NONE, 1'b0, SLOW_RES};
    dir_rows[12] = '{1'b0, RST_REGS, FK_INET, 4'd5, 8'd0, 32'hFFFFFFFF, 1'b0, FL_NONE, 1'b1,
                     SLOW_RES};
    dir_rows[13] = '{1'b1, '{1'b1, 1'b1, SEED_RESET, 32'hC0A80001, PORT_RESET}, FK_INET, 4'd5,
                     8'd0, 32'h0A000007, 1'b0, FL_NONE, 1'b1, '{1'b0, 32'h7, 1'b1}};
    dir_rows[14] = '{1'b0, RST_REGS, FK_INET, 4'd5, 8'd0, 32'h0A000007, 1'b0, FL_BCAST, 1'b1,
                     SLOW_RES};
    dir_rows[15] = '{1'b0, RST_REGS, FK_INET, 4'd5, 8'd150, 32'h0A0000AB, 1'b0, FL_NONE, 1'b1,
                     '{1'b0, 32'hAB, 1'b1}};
    dir_rows[16] = '{1'b0, RST_REGS, FK_INET, 4'd5, 8'd0, 32'h0A000009, 1'b0, FL_SHORT, 1'b1,
                     SLOW_RES};
    dir_rows[17] = '{1'b0, RST_REGS, FK_INET, 4'd5, 8'd0, 32'h0A000009, 1'b0, FL_ETYPE_HI, 1'b1,
                     SLOW_RES};
    dir_rows[18] = '{1'b0, RST_REGS, FK_INET, 4'd5, 8'd0, 32'h0A000009, 1'b1, FL_NONE, 1'b1,
                     SLOW_RES};
    dir_rows[19] = '{1'b0, RST_REGS, FK_NOISE, 4'd5, 8'd40, 32'h0, 1'b0, FL_NONE, 1'b0,
                     SLOW_RES};
    dir_rows[20] = '{1'b1, '{1'b1, 1'b0, SEED_RESET, 32'h0, PORT_RESET}, FK_INET, 4'd5, 8'd0,
                     32'h0, 1'b0, FL_NONE, 1'b1, SLOW_RES};
    dir_rows[21] = '{1'b1, RST_REGS, FK_TUNNEL, 4'd5, 8'd0, 32'hFFFFFFFF, 1'b0, FL_NONE, 1'b0,
                     SLOW_RES};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (dir_rows[i].wr) program_regs(dir_rows[i].regs);
      build_frame(dir_rows[i].kind, int'(dir_rows[i].ihl), int'(dir_rows[i].len),
                  dir_rows[i].addr, dir_rows[i].flaw);
      send_frame(dir_rows[i].chk_bad, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random phases: a new register setting every eight frames.
    while (bytes_sent < 1400) begin
      if (frames_sent % 8 == 0) begin
        rc.interface_mode = 1'($urandom_range(0, 1));
        rc.hash_mode = 1'($urandom_range(0, 1));
        rc.hash_seed = pick_word();
        rc.local_ipv4 = pick_word();
        case ($urandom_range(0, 4))
          0, 1: rc.tunnel_udp_port = PORT_RESET;
          2: rc.tunnel_udp_port = 16'h0000;
          3: rc.tunnel_udp_port = 16'hFFFF;
          default: rc.tunnel_udp_port = 16'($urandom);
        endcase
        program_regs(rc);
        sender_burst = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 9);
      if (r < 7) k = drv_cfg.interface_mode ? FK_INET : FK_TUNNEL;
      else if (r < 8) k = drv_cfg.interface_mode ? FK_TUNNEL : FK_INET;
      else k = FK_NOISE;
      ihl = ($urandom_range(0, 9) < 6) ? 5 : $urandom_range(0, 15);
      need = (k == FK_TUNNEL) ? int'(INNER_BASE) + 4 * ihl + 4 : int'(POS_DEST_IP) + 4;
      r = $urandom_range(0, 99);
      if (k == FK_NOISE) len = $urandom_range(1, 80);
      else if (r < 75) len = need + $urandom_range(0, 6);
      else if (r < 92) len = $urandom_range(1, need - 1);
      else len = $urandom_range(128, 170);
      fl = ($urandom_range(0, 9) < 7) ? FL_NONE : flaw_t'($urandom_range(1, 7));
      if ($urandom_range(0, 9) == 0) fl = FL_LOCAL;
      build_frame(k, ihl, len, $urandom, fl);
      send_frame($urandom_range(0, 7) == 0, 1'b0, SLOW_RES);
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (steer_expect.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end

endmodule

/* gtpu_ipv4_packet_steering_classifier_core.f */
rtl/gtpusc_pkg.sv
rtl/gtpusc_cfg.sv
rtl/gtpusc_crc.sv
rtl/gtpusc_parser.sv
rtl/gtpusc_pkg_unused_guard.sv
rtl/gtpu_ipv4_packet_steering_classifier_core.sv
rtl/gtpusc_checker.sv
bench/gtpu_ipv4_packet_steering_classifier_core_test.sv
